// ===== hdl/ddfr_pkg.sv =====
// Shared types, constants and the 5x3 digit font for the decimal digit row unit.
// No dependencies.
package ddfr_pkg;

  localparam int unsigned NumDigits  = 10;
  localparam int unsigned GlyphRows  = 5;
  localparam int unsigned GlyphCols  = 3;
  localparam int unsigned BinBits    = 31;
  localparam int unsigned PixBits    = GlyphCols * NumDigits;

  localparam logic [2:0] LastRow     = 3'd4;
  localparam logic [3:0] MaxCount    = 4'd10;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  // request to the row formatter: which row, how many digits, digits left-aligned
  typedef struct packed {
    logic [2:0] row;
    logic [3:0] count;
    bcd_t       digits;
  } row_req_t;

  // bit k of the result is column k of the glyph row
  function automatic logic [GlyphCols-1:0] font_row(input logic [2:0] row,
                                                    input logic [3:0] digit);
    logic [GlyphCols-1:0] m;
    m = 3'd0;
    case (row)
      3'd0: begin
        case (digit)
          4'd1:    m = 3'd2;
          4'd4:    m = 3'd5;
          4'd0, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: m = 3'd7;
          default: m = 3'd0;
        endcase
      end
      3'd1: begin
        case (digit)
          4'd0, 4'd4, 4'd8, 4'd9: m = 3'd5;
          4'd1:    m = 3'd2;
          4'd2, 4'd3, 4'd7: m = 3'd4;
          4'd5, 4'd6: m = 3'd1;
          default: m = 3'd0;
        endcase
      end
      3'd2: begin
        case (digit)
          4'd0:    m = 3'd5;
          4'd1:    m = 3'd2;
          4'd7:    m = 3'd4;
          4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9: m = 3'd7;
          default: m = 3'd0;
        endcase
      end
      3'd3: begin
        case (digit)
          4'd0, 4'd6, 4'd8: m = 3'd5;
          4'd1:    m = 3'd2;
          4'd2:    m = 3'd1;
          4'd3, 4'd4, 4'd5, 4'd7, 4'd9: m = 3'd4;
          default: m = 3'd0;
        endcase
      end
      3'd4: begin
        case (digit)
          4'd1:    m = 3'd2;
          4'd4, 4'd7: m = 3'd4;
          4'd0, 4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd9: m = 3'd7;
          default: m = 3'd0;
        endcase
      end
      default: m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/decimal_digit_font_rows_unit.sv =====
// Top level: sequencer around the shared BCD step unit and the row formatter.
// Depends on ddfr_pkg, ddfr_bcd_step, ddfr_row_fmt.
//
// An item is taken when start is high and busy is low. It is converted to BCD
// by 31 double-dabble steps (one per cycle through one shared add-3/shift unit),
// then the digits are shifted left to drop leading zeros (one digit per cycle,
// up to 10 digits), then five rows are sent, top row first, one per cycle with
// valid_o high for one cycle each; the receiver cannot stall them. busy stays
// high until the last row is registered, so a new item can be taken in the
// cycle that the last row is on the outputs and not earlier. Zero and negative
// values give five rows with digit_count 0 and no pixels.
module decimal_digit_font_rows_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  output logic        valid_o,
  output logic [2:0]  row_index_o,
  output logic [3:0]  digit_count_o,
  output logic [29:0] row_pixels_o,
  output logic        last_row_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StNorm,
    StEmit
  } state_e;

  state_e                          state_q;
  logic [ddfr_pkg::BinBits-1:0]    bin_q;
  logic [4:0]                      step_q;
  ddfr_pkg::bcd_t                  bcd_q;
  ddfr_pkg::bcd_t                  bcd_next;
  logic [3:0]                      count_q;
  logic [2:0]                      row_q;
  ddfr_pkg::row_req_t              req;
  logic [ddfr_pkg::PixBits-1:0]    pixels;

  ddfr_bcd_step u_step (
    .bcd_i (bcd_q),
    .bit_i (bin_q[ddfr_pkg::BinBits-1]),
    .bcd_o (bcd_next)
  );

  assign req.row    = row_q;
  assign req.count  = count_q;
  assign req.digits = bcd_q;

  ddfr_row_fmt u_fmt (
    .req_i    (req),
    .pixels_o (pixels)
  );

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      valid_o       <= 1'b0;
      step_q        <= '0;
      count_q       <= '0;
      row_q         <= '0;
      bin_q         <= '0;
      bcd_q         <= '0;
      row_index_o   <= '0;
      digit_count_o <= '0;
      row_pixels_o  <= '0;
      last_row_o    <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start) begin
            // negative values convert as zero and end up with no digits
            bin_q   <= value_i[31] ? '0 : value_i[ddfr_pkg::BinBits-1:0];
            bcd_q   <= '0;
            step_q  <= 5'(ddfr_pkg::BinBits - 1);
            count_q <= ddfr_pkg::MaxCount;
            state_q <= StConv;
          end
        end
        StConv: begin
          bcd_q  <= bcd_next;
          bin_q  <= {bin_q[ddfr_pkg::BinBits-2:0], 1'b0};
          step_q <= step_q - 5'd1;
          if (step_q == '0) begin
            state_q <= StNorm;
          end
        end
        StNorm: begin
          // drop leading zeros so the leftmost digit sits in the top slot
          if (count_q == '0 || bcd_q[ddfr_pkg::NumDigits-1] != 4'd0) begin
            row_q   <= '0;
            state_q <= StEmit;
          end else begin
            bcd_q   <= {bcd_q[ddfr_pkg::NumDigits-2:0], 4'd0};
            count_q <= count_q - 4'd1;
          end
        end
        StEmit: begin
          valid_o       <= 1'b1;
          row_index_o   <= row_q;
          digit_count_o <= count_q;
          row_pixels_o  <= pixels;
          last_row_o    <= (row_q == ddfr_pkg::LastRow);
          row_q         <= row_q + 3'd1;
          if (row_q == ddfr_pkg::LastRow) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // the five rows of an item come back to back, then nothing until a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_row_o |=> valid_o && row_index_o == $past(row_index_o) + 3'd1)
    else $error("row sequence broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_row_o |=> !valid_o)
    else $error("row after last row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !valid_o)
    else $error("accepted item not started");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> digit_count_o <= ddfr_pkg::MaxCount && row_index_o <= ddfr_pkg::LastRow)
    else $error("row fields out of range");

endmodule

// ===== hdl/ddfr_bcd_step.sv =====
// One double-dabble step: add-3 adjust on every BCD digit, then shift in one bit.
// Depends on ddfr_pkg.
module ddfr_bcd_step (
  input  ddfr_pkg::bcd_t bcd_i,
  input  logic           bit_i,
  output ddfr_pkg::bcd_t bcd_o
);

  ddfr_pkg::bcd_t                   adj;
  logic [4*ddfr_pkg::NumDigits-1:0] adj_bits;

  always_comb begin
    for (int i = 0; i < ddfr_pkg::NumDigits; i++) begin
      adj[i] = (bcd_i[i] >= 4'd5) ? bcd_i[i] + 4'd3 : bcd_i[i];
    end
  end

  assign adj_bits = adj;
  assign bcd_o    = {adj_bits[4*ddfr_pkg::NumDigits-2:0], bit_i};

endmodule

// ===== hdl/ddfr_row_fmt.sv =====
// Builds one packed pixel row from left-aligned BCD digits and a digit count.
// Depends on ddfr_pkg.
module ddfr_row_fmt (
  input  ddfr_pkg::row_req_t              req_i,
  output logic [ddfr_pkg::PixBits-1:0]    pixels_o
);

  // lane j shows digit j from the left, i.e. BCD slot NumDigits-1-j
  always_comb begin
    pixels_o = '0;
    for (int j = 0; j < ddfr_pkg::NumDigits; j++) begin
      if (4'(j) < req_i.count) begin
        pixels_o[ddfr_pkg::GlyphCols*j +: ddfr_pkg::GlyphCols] =
          ddfr_pkg::font_row(req_i.row, req_i.digits[ddfr_pkg::NumDigits-1-j]);
      end
    end
  end

endmodule

// ===== test/tb_decimal_digit_font_rows_unit.sv =====
// Testbench for decimal_digit_font_rows_unit: drives signed numbers, predicts the five
// font rows of each and checks every row strobe in order. Depends on ddfr_pkg and the RTL.
`timescale 1ns / 1ps

module tb_decimal_digit_font_rows_unit;

  localparam int unsigned RandItems  = 437;
  localparam int unsigned Phase1At   = 250;   // accepted items before sender idles 66%
  localparam int unsigned Phase2At   = 400;   // accepted items before sender stops idling
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned MaxReports = 10;

  // glyph masks, one 30-bit word per row, digit 9 in the top 3 bits
  localparam logic [ddfr_pkg::GlyphRows-1:0][ddfr_pkg::PixBits-1:0] DigitGlyphs = {
    {3'd7, 3'd7, 3'd4, 3'd7, 3'd7, 3'd4, 3'd7, 3'd7, 3'd2, 3'd7},
    {3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4, 3'd1, 3'd2, 3'd5},
    {3'd7, 3'd7, 3'd4, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd2, 3'd5},
    {3'd5, 3'd5, 3'd4, 3'd1, 3'd1, 3'd5, 3'd4, 3'd4, 3'd2, 3'd5},
    {3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd5, 3'd7, 3'd7, 3'd2, 3'd7}
  };

  typedef struct packed {
    logic [2:0]                   row;
    logic [3:0]                   count;
    logic [ddfr_pkg::PixBits-1:0] pixels;
    logic                         last;
  } font_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] value_i = 32'd0;
  logic        valid_o;
  logic [2:0]  row_index_o;
  logic [3:0]  digit_count_o;
  logic [29:0] row_pixels_o;
  logic        last_row_o;

  logic [31:0]   pending_values[$];
  font_row_t     rows_due[$];
  int unsigned   n_accepted = 0;
  int unsigned   n_errors = 0;
  int unsigned   quiet_cycles = 0;

  decimal_digit_font_rows_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .row_index_o   (row_index_o),
    .digit_count_o (digit_count_o),
    .row_pixels_o  (row_pixels_o),
    .last_row_o    (last_row_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // five rows per number; zero and negatives render no digits
  function automatic void queue_font_rows(input logic [31:0] num);
    logic [3:0]                   low_digits[ddfr_pkg::NumDigits];
    int unsigned                  n;
    int unsigned                  cnt;
    logic [ddfr_pkg::PixBits-1:0] pix;
    font_row_t                    fr;
    n = num;
    cnt = 0;
    if (!num[31]) begin
      while (n > 0 && cnt < ddfr_pkg::NumDigits) begin
        low_digits[cnt] = 4'(n % 10);
        n = n / 10;
        cnt++;
      end
    end
    for (int r = 0; r < ddfr_pkg::GlyphRows; r++) begin
      pix = '0;
      for (int j = 0; j < cnt; j++)
        pix[ddfr_pkg::GlyphCols*j +: ddfr_pkg::GlyphCols] =
          DigitGlyphs[r][ddfr_pkg::GlyphCols*low_digits[cnt-1-j] +: ddfr_pkg::GlyphCols];
      fr.row    = 3'(r);
      fr.count  = 4'(cnt);
      fr.pixels = pix;
      fr.last   = (3'(r) == ddfr_pkg::LastRow);
      rows_due  = {rows_due, fr};
    end
  endfunction

  function automatic void append_value(input logic [31:0] v);
    pending_values = {pending_values, v};
  endfunction

  // driver: start held until accepted, idles only between items
  always @(posedge clk_i) begin
    logic        took;
    logic        drain;
    int unsigned idle_pct;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        queue_font_rows(value_i);
        n_accepted++;
      end
      if (!(start && !took)) begin
        idle_pct = (n_accepted < Phase1At) ? 20 : (n_accepted < Phase2At) ? 66 : 0;
        // hold off after 25 items and at phase boundaries until all rows have come back
        drain = (n_accepted == 25 || n_accepted == Phase1At || n_accepted == Phase2At)
                && rows_due.size() != 0;
        if (pending_values.size() != 0 && !drain && $urandom_range(99, 0) >= idle_pct) begin
          value_i <= pending_values.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is one row, checked against the oldest prediction
  always @(posedge clk_i) begin
    font_row_t want;
    if (rst_ni && valid_o) begin
      if (rows_due.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("unexpected row: row=%0d count=%0d pix=%h last=%b",
                   row_index_o, digit_count_o, row_pixels_o, last_row_o);
      end else begin
        want = rows_due.pop_front();
        if (want.row != row_index_o || want.count != digit_count_o ||
            want.pixels != row_pixels_o || want.last != last_row_o) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display({"row mismatch: exp row=%0d count=%0d pix=%h last=%b,",
                      " got row=%0d count=%0d pix=%h last=%b"},
                     want.row, want.count, want.pixels, want.last,
                     row_index_o, digit_count_o, row_pixels_o, last_row_o);
        end
      end
    end
  end

  // watchdog on cycles with no item taken and no row seen
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    // directed: extremes, every digit, sign and zero cases
    append_value(32'd0);
    append_value(32'd1);
    append_value(32'hFFFF_FFFF);
    append_value(32'h7FFF_FFFF);
    append_value(32'h8000_0000);
    append_value(32'h8000_0001);
    append_value(32'd9);
    append_value(32'd10);
    append_value(32'd99);
    append_value(32'd100);
    append_value(32'd1234567890);
    append_value(32'd987654321);
    append_value(32'd999999999);
    append_value(32'd1000000000);
    append_value(32'd2000000000);
    append_value(32'd1111111111);
    append_value(32'd2147483640);
    append_value(32'd5);
    append_value(-32'sd5);
    append_value(32'd4444444);
    append_value(32'd7070707);
    append_value(32'h5555_5555);
    append_value(32'h2AAA_AAAA);
    for (int i = 0; i < RandItems; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        len = $urandom_range(ddfr_pkg::NumDigits, 1);
        lo = 1;
        for (int k = 1; k < len; k++) lo = lo * 10;
        hi = (len == ddfr_pkg::NumDigits) ? 32'h7FFF_FFFF : lo * 10 - 1;
        append_value($urandom_range(hi, lo));
      end else if (pick < 88) begin
        append_value($urandom | 32'h8000_0000);
      end else if (pick < 91) begin
        append_value(32'd0);
      end else begin
        append_value($urandom);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // checked away from the driving edge so driver updates have settled
    while (pending_values.size() != 0 || start) @(negedge clk_i);
    while (rows_due.size() != 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);

    if (n_errors == 0 && rows_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
